FILE: rtl/tpes_pkg.sv
// Shared types and constants of the timed priority event scheduler.
// Used by tpes_cell, tpes_queue and timed_priority_event_scheduler_core.
package tpes_pkg;

	localparam int QueueDepthDef = 16;
	localparam int NumPrioDef    = 4;
	localparam int TagBits       = 16;
	localparam int TimeBits      = 32;
	localparam int RunBits       = 8;

	localparam logic [TimeBits-1:0] TimeNone = '1;

	// One stored event
	typedef struct packed {
		logic [TimeBits-1:0] ht;
		logic [TimeBits-1:0] st;
		logic [TagBits-1:0]  tag;
	} entry_t;

	// Commands
	typedef enum logic [2:0] {
		CMD_INSERT = 3'd0,
		CMD_PICK   = 3'd1,
		CMD_REMOVE = 3'd2,
		CMD_QUERY  = 3'd3,
		CMD_CLEAR  = 3'd4
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [7:0] {
		REG_ENABLE    = 8'd0,
		REG_LIMIT_VIP = 8'd1,
		REG_LIMIT_IMM = 8'd2,
		REG_LIMIT_HI  = 8'd3
	} reg_idx_t;

	// Queue operations
	typedef enum logic [2:0] {
		QOP_NONE,
		QOP_INSERT,
		QOP_FRONT,
		QOP_POP,
		QOP_DEL,
		QOP_CLEAR
	} q_op_t;

	// Per-cell move
	typedef enum logic [1:0] {
		MV_KEEP,
		MV_NEW,
		MV_LEFT,
		MV_RIGHT
	} cell_mv_t;

	typedef struct packed {
		q_op_t  op;
		entry_t ent;
	} q_ctrl_t;

	typedef struct packed {
		entry_t head;
		logic   nonempty;
		logic   full;
		logic   any_match;
	} q_stat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RESP
	} sched_state_t;

endpackage

FILE: rtl/tpes_cell.sv
// One storage cell of a queue row: holds an event and compares it.
// Depends on tpes_pkg.
module tpes_cell (
	input  logic                       clk,
	input  tpes_pkg::cell_mv_t         mv,
	input  tpes_pkg::entry_t           new_ent,
	input  tpes_pkg::entry_t           left_ent,
	input  tpes_pkg::entry_t           right_ent,
	input  logic [tpes_pkg::TagBits-1:0] match_tag,
	input  logic [tpes_pkg::TagBits-1:0] match_mask,
	output tpes_pkg::entry_t           ent,
	output logic                       le,
	output logic                       hit
);
	import tpes_pkg::*;

	entry_t ent_q;

	// load the new entry or the entry of the selected neighbor
	always_ff @(posedge clk) begin
		case (mv)
			MV_NEW:   ent_q <= new_ent;
			MV_LEFT:  ent_q <= left_ent;
			MV_RIGHT: ent_q <= right_ent;
			default:  ent_q <= ent_q;
		endcase
	end

	assign ent = ent_q;
	assign le  = (ent_q.ht <= new_ent.ht);
	assign hit = (((ent_q.tag ^ match_tag) & match_mask) == '0);

endmodule

FILE: rtl/tpes_queue.sv
// One time-sorted queue: a row of tpes_cell plus a fill count.
// Depends on tpes_pkg and tpes_cell.
module tpes_queue #(
	parameter int QueueDepth = tpes_pkg::QueueDepthDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tpes_pkg::q_ctrl_t            ctrl,
	input  logic [tpes_pkg::TagBits-1:0] match_tag,
	input  logic [tpes_pkg::TagBits-1:0] match_mask,
	output tpes_pkg::q_stat_t            stat
);
	import tpes_pkg::*;

	localparam int LenW = $clog2(QueueDepth + 1);

	logic [LenW-1:0] len_q;
	entry_t          ents [QueueDepth];
	logic            les  [QueueDepth];
	logic            hits [QueueDepth];
	logic            vld  [QueueDepth];
	logic            keep [QueueDepth];
	logic            delb [QueueDepth];
	cell_mv_t        mvs  [QueueDepth];
	entry_t          new_ent;
	logic            any_hit;

	// front insert is clamped to the head's time
	always_comb begin
		new_ent = ctrl.ent;
		if (ctrl.op == QOP_FRONT && len_q != '0 && ents[0].ht < ctrl.ent.ht)
			new_ent.ht = ents[0].ht;
	end

	// per-cell move decisions
	always_comb begin
		any_hit = 1'b0;
		for (int i = 0; i < QueueDepth; i++) begin
			vld[i]  = (LenW'(i) < len_q);
			keep[i] = vld[i] & les[i];
			any_hit = any_hit | (vld[i] & hits[i]);
			delb[i] = any_hit;
		end
		for (int i = 0; i < QueueDepth; i++) begin
			case (ctrl.op)
				QOP_INSERT: begin
					if (keep[i])
						mvs[i] = MV_KEEP;
					else if (i == 0)
						mvs[i] = MV_NEW;
					else if (keep[(i > 0) ? i - 1 : 0])
						mvs[i] = MV_NEW;
					else
						mvs[i] = MV_LEFT;
				end
				QOP_FRONT: mvs[i] = (i == 0) ? MV_NEW : MV_LEFT;
				QOP_POP:   mvs[i] = MV_RIGHT;
				QOP_DEL:   mvs[i] = delb[i] ? MV_RIGHT : MV_KEEP;
				default:   mvs[i] = MV_KEEP;
			endcase
		end
	end

	// the cell row
	for (genvar g = 0; g < QueueDepth; g++) begin : g_cell
		tpes_cell u_cell (
			.clk        (clk),
			.mv         (mvs[g]),
			.new_ent    (new_ent),
			.left_ent   ((g == 0) ? new_ent : ents[(g > 0) ? g - 1 : 0]),
			.right_ent  ((g == QueueDepth - 1) ? ents[g] :
			             ents[(g < QueueDepth - 1) ? g + 1 : g]),
			.match_tag  (match_tag),
			.match_mask (match_mask),
			.ent        (ents[g]),
			.le         (les[g]),
			.hit        (hits[g])
		);
	end

	// fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			case (ctrl.op)
				QOP_INSERT, QOP_FRONT: len_q <= len_q + 1'b1;
				QOP_POP, QOP_DEL:      len_q <= len_q - 1'b1;
				QOP_CLEAR:             len_q <= '0;
				default:               len_q <= len_q;
			endcase
		end
	end

	assign stat.head      = ents[0];
	assign stat.nonempty  = (len_q != '0);
	assign stat.full      = (len_q == LenW'(QueueDepth));
	assign stat.any_match = any_hit;

endmodule

FILE: rtl/timed_priority_event_scheduler_core.sv
// Top level of the timed priority event scheduler: command sequencer,
// pick arbitration and result register. Depends on tpes_pkg, tpes_queue.
//
// channel | direction | handshake                  | payload
// s_axis  | in        | s_axis_tvalid/s_axis_tready | tuser cmd, tdata command fields
// m_axis  | out       | m_axis_tvalid/m_axis_tready | tdata result fields
// cfg     | in        | cfg_valid/cfg_ready         | cfg_index, cfg_data
//
// Insert, pick, query and clear go through the accept, execute and respond steps.
// A remove deletes one match per queue per cycle in the cell rows and repeats
// its execute step until no queue holds a match.
// Reset empties all queues at once through their fill counts; no clearing pass.
// A held result stalls the block in its respond step; a new command can be
// accepted while the previous result still waits in the output register.
module timed_priority_event_scheduler_core #(
	parameter int QueueDepth = tpes_pkg::QueueDepthDef,
	parameter int NumPrio    = tpes_pkg::NumPrioDef
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// priority_req[2:0], head_insert[3], handle_time[35:4], send_time[67:36],
	// event_tag[83:68], match_mask[99:84], now[131:100], zero fill
	input  logic [135:0] s_axis_tdata,
	// cmd[2:0]
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// event_valid[0], out_tag[16:1], out_priority[19:17], next_wake_time[51:20],
	// notify[52], found[53], dropped[54], queue_empty[55]
	output logic [55:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [7:0]   cfg_data
);
	import tpes_pkg::*;

	localparam int NumQ = NumPrio + 1;
	localparam int SelW = $clog2(NumPrio);

	sched_state_t state_q, state_d;

	// configuration
	logic               enable_q;
	logic [RunBits-1:0] lim_vip_q, lim_imm_q, lim_hi_q;

	// latched command
	logic [2:0]          cmd_q, prio_q;
	logic                front_q;
	logic [TimeBits-1:0] ht_q, st_q, now_q;
	logic [TagBits-1:0]  tag_q, mask_q;

	// scheduler state
	logic [RunBits-1:0]  rc_q [NumPrio];
	logic                idle_mode_q;
	logic [TimeBits-1:0] idle_stamp_q, wake_q;

	// result being built and the output register
	logic                ev_q, notify_q, found_q, dropped_q;
	logic [TagBits-1:0]  otag_q;
	logic [2:0]          oprio_q;
	logic [TimeBits-1:0] nwake_q;
	logic                out_vld_q;
	logic [55:0]         out_data_q;

	q_ctrl_t ctrl [NumQ];
	q_stat_t stat [NumQ];

	// pick arbitration
	logic [TimeBits-1:0] pk_wake;
	logic                pk_have, pk_stop, pk_due, idle_ok;
	logic [SelW-1:0]     pk_sel;
	logic [TagBits-1:0]  pk_tag;
	logic [NumPrio-1:0]  pk_inc;
	logic [TimeBits-1:0] stamp_eff;
	logic [RunBits-1:0]  lim;
	logic                ins_ok, ins_full, any_match, all_empty;

	for (genvar q = 0; q < NumQ; q++) begin : g_queue
		tpes_queue #(.QueueDepth(QueueDepth)) u_queue (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl[q]),
			.match_tag  (tag_q),
			.match_mask (mask_q),
			.stat       (stat[q])
		);
	end

	// walk queue fronts in priority order with a running wake minimum
	always_comb begin
		pk_wake = TimeNone;
		pk_have = 1'b0;
		pk_stop = 1'b0;
		pk_sel  = '0;
		pk_tag  = '0;
		pk_inc  = '0;
		pk_due  = 1'b0;
		lim     = lim_hi_q;
		for (int i = 0; i < NumPrio; i++) begin
			if (!pk_stop) begin
				pk_due = 1'b0;
				if (stat[i].nonempty && stat[i].head.ht < pk_wake) begin
					pk_wake = stat[i].head.ht;
					pk_due  = (stat[i].head.ht <= now_q);
				end
				if (pk_due) begin
					if (pk_sel == '0)
						lim = lim_vip_q;
					else if (pk_sel == SelW'(1))
						lim = lim_imm_q;
					else
						lim = lim_hi_q;
					if (pk_have && rc_q[pk_sel] < lim) begin
						pk_inc[pk_sel] = 1'b1;
						pk_stop        = 1'b1;
					end else begin
						pk_have = 1'b1;
						pk_sel  = SelW'(i);
						pk_tag  = stat[i].head.tag;
					end
				end
			end
		end
		stamp_eff = idle_mode_q ? idle_stamp_q : now_q;
		idle_ok   = stat[NumPrio].nonempty && stat[NumPrio].head.st <= stamp_eff &&
		            stat[NumPrio].head.ht <= now_q;
	end

	// insert target status, match summary, emptiness
	always_comb begin
		ins_ok    = 1'b0;
		ins_full  = 1'b0;
		any_match = 1'b0;
		all_empty = 1'b1;
		for (int q = 0; q < NumQ; q++) begin
			if (int'(prio_q) == q) begin
				ins_ok   = 1'b1;
				ins_full = stat[q].full;
			end
			any_match = any_match | stat[q].any_match;
			all_empty = all_empty & ~stat[q].nonempty;
		end
	end

	// queue operations, applied in the execute step
	always_comb begin
		for (int q = 0; q < NumQ; q++) begin
			ctrl[q].op  = QOP_NONE;
			ctrl[q].ent = '{ht: ht_q, st: st_q, tag: tag_q};
			if (state_q == ST_EXEC && enable_q) begin
				case (cmd_q)
					CMD_INSERT:
						if (int'(prio_q) == q && !stat[q].full)
							ctrl[q].op = front_q ? QOP_FRONT : QOP_INSERT;
					CMD_PICK:
						if ((pk_have && q < NumPrio && SelW'(q) == pk_sel) ||
						    (!pk_have && q == NumPrio && idle_ok))
							ctrl[q].op = QOP_POP;
					CMD_REMOVE:
						if (stat[q].any_match)
							ctrl[q].op = QOP_DEL;
					CMD_CLEAR:
						ctrl[q].op = QOP_CLEAR;
					default:
						ctrl[q].op = QOP_NONE;
				endcase
			end
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:
				if (s_axis_tvalid)
					state_d = ST_EXEC;
			ST_EXEC:
				if (!(enable_q && cmd_q == CMD_REMOVE && any_match))
					state_d = ST_RESP;
			ST_RESP:
				if (!out_vld_q || m_axis_tready)
					state_d = ST_IDLE;
			default:
				state_d = ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		s_axis_tready = (state_q == ST_IDLE);
		cfg_ready     = 1'b1;
		m_axis_tvalid = out_vld_q;
		m_axis_tdata  = out_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b1;
			lim_vip_q <= RunBits'(5);
			lim_imm_q <= RunBits'(5);
			lim_hi_q  <= RunBits'(5);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ENABLE:    enable_q  <= cfg_data[0];
				REG_LIMIT_VIP: lim_vip_q <= cfg_data;
				REG_LIMIT_IMM: lim_imm_q <= cfg_data;
				REG_LIMIT_HI:  lim_hi_q  <= cfg_data;
				default:       enable_q  <= enable_q;
			endcase
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_axis_tvalid) begin
			cmd_q   <= s_axis_tuser;
			prio_q  <= s_axis_tdata[2:0];
			front_q <= s_axis_tdata[3];
			ht_q    <= s_axis_tdata[35:4];
			st_q    <= s_axis_tdata[67:36];
			tag_q   <= s_axis_tdata[83:68];
			mask_q  <= s_axis_tdata[99:84];
			now_q   <= s_axis_tdata[131:100];
		end
	end

	// scheduler state and result build-up
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumPrio; i++)
				rc_q[i] <= '0;
			idle_mode_q  <= 1'b0;
			idle_stamp_q <= '0;
			wake_q       <= TimeNone;
			ev_q         <= 1'b0;
			notify_q     <= 1'b0;
			found_q      <= 1'b0;
			dropped_q    <= 1'b0;
			otag_q       <= '0;
			oprio_q      <= '0;
			nwake_q      <= TimeNone;
		end else if (state_q == ST_IDLE && s_axis_tvalid) begin
			ev_q      <= 1'b0;
			notify_q  <= 1'b0;
			found_q   <= 1'b0;
			dropped_q <= 1'b0;
			otag_q    <= '0;
			oprio_q   <= '0;
			nwake_q   <= TimeNone;
		end else if (state_q == ST_EXEC) begin
			if (!enable_q) begin
				dropped_q <= 1'b1;
			end else begin
				case (cmd_q)
					CMD_INSERT:
						if (ins_ok) begin
							if (ins_full)
								dropped_q <= 1'b1;
							else
								notify_q <= (int'(prio_q) < NumPrio) && (ht_q < wake_q);
						end
					CMD_PICK: begin
						wake_q <= pk_wake;
						if (pk_have) begin
							for (int i = 0; i < NumPrio; i++) begin
								if (SelW'(i) < pk_sel)
									rc_q[i] <= '0;
								else if (pk_inc[i])
									rc_q[i] <= rc_q[i] + 1'b1;
							end
							idle_mode_q <= 1'b0;
							ev_q        <= 1'b1;
							otag_q      <= pk_tag;
							oprio_q     <= 3'(pk_sel);
						end else begin
							if (!idle_mode_q) begin
								idle_stamp_q <= now_q;
								idle_mode_q  <= 1'b1;
							end
							if (idle_ok) begin
								ev_q    <= 1'b1;
								otag_q  <= stat[NumPrio].head.tag;
								oprio_q <= 3'(NumPrio);
							end else begin
								nwake_q <= pk_wake;
							end
						end
					end
					CMD_REMOVE, CMD_QUERY:
						found_q <= found_q | any_match;
					default:
						found_q <= found_q;
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_RESP && (!out_vld_q || m_axis_tready)) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_RESP && (!out_vld_q || m_axis_tready))
			out_data_q <= {all_empty, dropped_q, found_q, notify_q,
			               nwake_q, oprio_q, otag_q, ev_q};
	end

endmodule
